// ----- rtl/utf8_text_validator_top_assert.svh -----
// Assertion macros used by the checker of the UTF-8 text validator.
`ifndef UTF8_TEXT_VALIDATOR_TOP_ASSERT_SVH
`define UTF8_TEXT_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define UTV_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8 validator assertion failed");

// Next-cycle implication, ignored while reset is high.
`define UTV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8 validator assertion failed");

// Next-cycle implication that is checked during reset as well.
`define UTV_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("utf8 validator assertion failed");

`endif

// ----- rtl/utf8v_pkg.sv -----
`default_nettype none

package utf8v_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;

   localparam logic [BYTE_W-1:0] BYTE_TERM      = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_PRINT_MIN = 8'h20;
   localparam logic [BYTE_W-1:0] BYTE_DEL       = 8'h7F;
   localparam logic [BYTE_W-1:0] BYTE_ASCII_END = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK     = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE     = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK     = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE     = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK     = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE     = 8'hF0;

   localparam logic [CP_W-1:0] CP_MIN_2      = 21'h00080;
   localparam logic [CP_W-1:0] CP_MIN_3      = 21'h00800;
   localparam logic [CP_W-1:0] CP_MIN_4      = 21'h10000;
   localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
   localparam logic [CP_W-1:0] CP_C1_LO      = 21'h00080;
   localparam logic [CP_W-1:0] CP_C1_HI      = 21'h0009F;
   localparam logic [CP_W-1:0] CP_SURR_LO    = 21'h0D800;
   localparam logic [CP_W-1:0] CP_SURR_HI    = 21'h0DFFF;

   localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd32;

   // Configuration register indexes.
   typedef enum logic {
      CSR_MAX_LEN     = 1'b0,
      CSR_ALLOW_EMPTY = 1'b1
   } utf8v_csr_type;

   // Running decode state of the current string, apart from the byte count.
   typedef struct packed {
      logic [1:0]      pending;
      logic [1:0]      seq_len;
      logic [CP_W-1:0] code_point;
      logic            fault;
   } utf8v_seq_type;

   // Verdict produced by a terminator.
   typedef struct packed {
      logic              ok;
      logic [BYTE_W-1:0] length;
   } utf8v_verdict_type;

endpackage

`default_nettype wire

// ----- rtl/utf8v_step.sv -----
`default_nettype none

module utf8v_step #(
   parameter int COUNT_BITS = 8
) (
   input  wire logic [COUNT_BITS-1:0]          count_i,
   input  wire utf8v_pkg::utf8v_seq_type       seq_i,
   input  wire logic [utf8v_pkg::BYTE_W-1:0]   data_byte,
   input  wire logic [utf8v_pkg::BYTE_W-1:0]   max_len,
   input  wire logic                           allow_empty,
   output logic [COUNT_BITS-1:0]               count_o,
   output utf8v_pkg::utf8v_seq_type            seq_o,
   output utf8v_pkg::utf8v_verdict_type        verdict_o
);
   import utf8v_pkg::*;

   localparam int CW = (COUNT_BITS > BYTE_W) ? COUNT_BITS : BYTE_W;
   localparam logic [CW-1:0] COUNT_CAP = CW'((1 << COUNT_BITS) - 1);

   logic [CW-1:0]   count_ext;
   logic [CW-1:0]   max_ext;
   logic [CW-1:0]   cap;
   logic [CP_W-1:0] cp_next;

   // A completed sequence is rejected if overlong, out of range, a C1
   // control or a surrogate.
   function automatic logic point_bad(input logic [CP_W-1:0] cp, input logic [1:0] extra);
      logic bad;
      bad = 1'b0;
      if (extra == 2'd1 && cp < CP_MIN_2) bad = 1'b1;
      if (extra == 2'd2 && cp < CP_MIN_3) bad = 1'b1;
      if (extra == 2'd3 && cp < CP_MIN_4) bad = 1'b1;
      if (cp > CP_MAX) bad = 1'b1;
      if (cp >= CP_C1_LO && cp <= CP_C1_HI) bad = 1'b1;
      if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) bad = 1'b1;
      return bad;
   endfunction

   assign count_ext = CW'(count_i);
   assign max_ext   = CW'(max_len);
   assign cap       = (max_ext < COUNT_CAP) ? max_ext : COUNT_CAP;
   assign cp_next   = {seq_i.code_point[CP_W-7:0], data_byte[5:0]};

   assign verdict_o.ok = !seq_i.fault && (seq_i.pending == 2'd0) && (count_ext < max_ext) &&
                         ((count_i != '0) || allow_empty);
   assign verdict_o.length = count_ext[BYTE_W-1:0];

   always_comb begin
      count_o = count_i;
      seq_o   = seq_i;
      if (data_byte == BYTE_TERM) begin
         count_o = '0;
         seq_o   = '0;
      end else begin
         if (count_ext >= cap) begin
            seq_o.fault = 1'b1;
         end else begin
            count_o = count_i + COUNT_BITS'(1);
         end
         if (!seq_o.fault) begin
            if (seq_i.pending == 2'd0) begin
               priority if (data_byte < BYTE_PRINT_MIN || data_byte == BYTE_DEL) begin
                  seq_o.fault = 1'b1;
               end else if (data_byte < BYTE_ASCII_END) begin
                  seq_o.fault = 1'b0;
               end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
                  seq_o.code_point = CP_W'(data_byte[4:0]);
                  seq_o.fault      = (data_byte[4:0] == 5'd0);
                  seq_o.pending    = 2'd1;
                  seq_o.seq_len    = 2'd1;
               end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
                  seq_o.code_point = CP_W'(data_byte[3:0]);
                  seq_o.pending    = 2'd2;
                  seq_o.seq_len    = 2'd2;
               end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
                  seq_o.code_point = CP_W'(data_byte[2:0]);
                  seq_o.pending    = 2'd3;
                  seq_o.seq_len    = 2'd3;
               end else begin
                  seq_o.fault = 1'b1;
               end
            end else if (data_byte[7:6] != 2'b10) begin
               seq_o.fault = 1'b1;
            end else begin
               seq_o.pending = seq_i.pending - 2'd1;
               if (seq_i.pending == 2'd1) begin
                  seq_o.fault      = point_bad(cp_next, seq_i.seq_len);
                  seq_o.seq_len    = 2'd0;
                  seq_o.code_point = '0;
               end else begin
                  seq_o.code_point = cp_next;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/utf8_text_validator_top.sv -----
// A terminator byte is first held in the input register; its verdict is then registered in
//    the result register and shown on rsp_ once that register has room.
// Throughput: one byte per cycle; the input register and the result register are parted,
//    so only a stalled verdict with another terminator behind it holds the input.
// Reset (synchronous, active high) empties both registers, clears the string state and
//    sets max_len to 32 and allow_empty to 0.
`default_nettype none

module utf8_text_validator_top #(
   parameter int COUNT_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Input byte stream.
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [utf8v_pkg::BYTE_W-1:0] req_data_byte,
   // Verdict stream, one transaction per terminated string.
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid_res,
   output logic [utf8v_pkg::BYTE_W-1:0]      rsp_text_length,
   // Configuration writes.
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire utf8v_pkg::utf8v_csr_type     csr_index,
   input  wire logic [utf8v_pkg::BYTE_W-1:0] csr_wdata
);
   import utf8v_pkg::*;

   // Input register: holds the accepted byte until the decoder consumes it.
   logic                  s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]     s1_byte_ff, s1_byte_in;

   // Running state of the string under decode.
   logic [COUNT_BITS-1:0] count_ff, count_in;
   utf8v_seq_type         seq_ff, seq_in;

   // Result register that carries the verdict transaction.
   logic                  rsp_valid_ff, rsp_valid_in;
   utf8v_verdict_type     verdict_ff, verdict_in;

   // Configuration registers.
   logic [BYTE_W-1:0]     max_len_ff, max_len_in;
   logic                  allow_empty_ff, allow_empty_in;

   logic [COUNT_BITS-1:0] step_count;
   utf8v_seq_type         step_seq;
   utf8v_verdict_type     step_verdict;
   logic                  out_free;
   logic                  advance;
   logic                  is_term;

   utf8v_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .count_i     (count_ff),
      .seq_i       (seq_ff),
      .data_byte   (s1_byte_ff),
      .max_len     (max_len_ff),
      .allow_empty (allow_empty_ff),
      .count_o     (step_count),
      .seq_o       (step_seq),
      .verdict_o   (step_verdict)
   );

   // A plain byte always moves on; a terminator needs room in the result register,
   // which is free when empty or when its transaction is being taken this cycle.
   assign is_term  = (s1_byte_ff == BYTE_TERM);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = s1_valid_ff && (!is_term || out_free);
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_byte_in  = req_data_byte;
      end
   end

   // The string state moves only when the held byte is consumed; a terminator
   // clears it for the next string.
   always_comb begin
      count_in = count_ff;
      seq_in   = seq_ff;
      if (advance) begin
         count_in = step_count;
         seq_in   = step_seq;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      if (advance && is_term) begin
         rsp_valid_in = 1'b1;
         verdict_in   = step_verdict;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Writes are taken at any time; the user changes settings only while idle.
   assign csr_ready = 1'b1;

   always_comb begin
      max_len_in     = max_len_ff;
      allow_empty_in = allow_empty_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LEN:     max_len_in     = csr_wdata;
            CSR_ALLOW_EMPTY: allow_empty_in = csr_wdata[0];
            default:         max_len_in     = max_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         count_ff       <= '0;
         seq_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         max_len_ff     <= MAX_LEN_RESET;
         allow_empty_ff <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         count_ff       <= count_in;
         seq_ff         <= seq_in;
         rsp_valid_ff   <= rsp_valid_in;
         max_len_ff     <= max_len_in;
         allow_empty_ff <= allow_empty_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = verdict_ff.ok;
   assign rsp_text_length = verdict_ff.length;

endmodule

`default_nettype wire

// ----- rtl/utf8v_checker.sv -----
`default_nettype none

`include "utf8_text_validator_top_assert.svh"

module utf8v_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic [utf8v_pkg::BYTE_W-1:0] req_data_byte,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_valid_res,
   input wire logic [utf8v_pkg::BYTE_W-1:0] rsp_text_length
);
   import utf8v_pkg::*;

   // A verdict held by the output side keeps its contents.
   `UTV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_valid_res) && $stable(rsp_text_length))

   // Reset leaves no verdict pending.
   `UTV_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // A newly raised verdict must trace back to a terminator byte accepted on the request side.
   `UTV_ASSERT_SAME(a_rsp_from_term, $rose(rsp_valid), $past(req_valid && !req_stall && req_data_byte == BYTE_TERM, 2))

   // An accepted string is always shorter than 255 bytes, the largest max_len.
   `UTV_ASSERT_SAME(a_ok_length, rsp_valid && rsp_valid_res, rsp_text_length != 8'hFF)

endmodule

bind utf8_text_validator_top utf8v_checker u_checker (.*);

`default_nettype wire
